### hdl/sdaf_pkg.sv
// Shared sizes, character codes and status types for the signed decimal ASCII formatter.
// No dependencies.
package sdaf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_BITS = 4;
    localparam int BCD_BITS   = MAX_DIGITS * DIGIT_BITS;
    localparam int IDX_BITS   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam int CHAR_BITS  = 7;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 7'd57;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

    // Converter status seen by the sequencer
    typedef struct packed {
        logic done;  // one-cycle pulse, BCD result valid
        logic ovf;   // magnitude had more digits than the BCD register holds
    } sdaf_conv_stat_t;

endpackage

### hdl/sdaf_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on sdaf_pkg.
module sdaf_dabble import sdaf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] mag,
    output logic [BCD_BITS-1:0]   bcd,
    output sdaf_conv_stat_t       stat
);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   adj;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic                  ovf_reg;

    // Add 3 to every digit of 5 or more before the doubling shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end else begin
                adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mag_reg <= mag;
                bcd_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= CNT_BITS'(VALUE_BITS - 1);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                bcd_reg <= {adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                // a carry out of the top digit is a multiple of 10^MAX_DIGITS: dropped
                ovf_reg <= ovf_reg | adj[BCD_BITS-1];
                mag_reg <= {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign bcd       = bcd_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

### hdl/signed_decimal_ascii_formatter_core.sv
// Top level of the signed decimal ASCII formatter: sequencer and output register.
// Depends on sdaf_pkg and sdaf_dabble.
//
// Usage:
//   s_value carries one signed two's complement integer per item (valid/ready).
//   m_ascii_char / m_last carry one ASCII character per item, most significant
//   character first: an optional '-', then the decimal digits without leading
//   zeros. Zero prints as a single '0'. m_last marks the final character.
//   The most negative value prints as its true magnitude (2147483648).
// Timing:
//   One number at a time. After acceptance the magnitude is shifted into a
//   BCD register one bit per cycle, then the sequencer picks the leading
//   digit, then one character leaves per cycle while the receiver takes them.
//   s_ready rises as soon as the last character sits in the output register,
//   so the next number can start while that character still waits.
// Stalls: while m_ready is low the output register holds its character and
//   the sequencer waits; nothing is dropped.
// Reset: aresetn (synchronous, active low) returns to idle and empties the
//   output register. There is no other state to clear.
module signed_decimal_ascii_formatter_core import sdaf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_BITS-1:0]  m_ascii_char,
    output logic                  m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t                state_reg;
    logic                  neg_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [CHAR_BITS-1:0]  m_char_reg;
    logic                  m_last_reg;

    logic                  accept;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_BITS-1:0]   bcd;
    sdaf_conv_stat_t       conv_stat;
    logic [IDX_BITS-1:0]   lead;
    logic [DIGIT_BITS-1:0] digit;
    logic                  out_free;
    logic                  emit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // A character is loaded whenever the sequencer has one and the register is free
    assign emit         = out_free && (state_reg inside {ST_SIGN, ST_DIGIT});
    assign m_valid_next = emit || (m_valid_reg && !m_ready);

    // Magnitude in VALUE_BITS bits; the most negative value wraps to 2^(VALUE_BITS-1)
    assign mag = s_value[VALUE_BITS-1] ? (~s_value + 1'b1) : s_value;

    sdaf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (mag),
        .bcd     (bcd),
        .stat    (conv_stat)
    );

    // Most significant nonzero digit; all digits are kept on saturation
    always_comb begin
        lead = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                lead = IDX_BITS'(i);
            end
        end
        if (conv_stat.ovf) begin
            lead = IDX_BITS'(MAX_DIGITS - 1);
        end
    end

    assign digit = bcd[DIGIT_BITS*int'(idx_reg) +: DIGIT_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            neg_reg     <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        neg_reg   <= s_value[VALUE_BITS-1];
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_stat.done) begin
                        idx_reg   <= lead;
                        state_reg <= neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_char_reg  <= CHAR_MINUS;
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_DIGIT;
                    end
                end
                ST_DIGIT: begin
                    if (out_free) begin
                        m_char_reg  <= CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, digit};
                        m_last_reg  <= (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last       = m_last_reg;

    // Converter finishes only while the sequencer waits for it
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_stat.done |-> state_reg == ST_CONV)
        else $error("converter done outside conversion");

    // Every emitted character is a minus sign or a decimal digit
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_reg == CHAR_MINUS ||
                         (m_char_reg >= CHAR_ZERO && m_char_reg <= CHAR_NINE)))
        else $error("character out of set");

    // Emitting the units digit closes the run and frees the input
    a_last_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT && out_free && idx_reg == '0) |=>
            (m_valid_reg && m_last_reg && state_reg == ST_IDLE))
        else $error("run not closed on units digit");

    // A minus sign is never flagged last
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_char_reg == CHAR_MINUS) |-> !m_last_reg)
        else $error("sign flagged last");

endmodule

### test/signed_decimal_ascii_formatter_core_tb.sv
// Self-checking testbench for signed_decimal_ascii_formatter_core: numbers in, ASCII digits out.
// Depends on sdaf_pkg and the formatter RTL; a small scoreboard class predicts each character.
module signed_decimal_ascii_formatter_core_tb;
    import sdaf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 4;
    localparam int RADIX        = 10;
    localparam int DRAIN_CYCLES = 60;    // margin above the worst time for one number to finish
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs up the input
    localparam int PHASE_ITEMS  = 50;
    localparam int PRESS_ITEMS  = 10;

    // One expected character on the output channel
    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } ascii_item_t;

    // Scoreboard: turns each accepted number into its character run and
    // compares outgoing characters in order against it.
    class decimal_scoreboard;
        ascii_item_t char_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void push_char(logic [CHAR_BITS-1:0] ch, logic last);
            ascii_item_t c;
            c.ch   = ch;
            c.last = last;
            char_q.push_back(c);
        endfunction

        // Decimal expansion of one accepted number
        function void note_value(logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] mag;
            logic                  neg;
            logic [3:0]            digs [MAX_DIGITS];
            int                    nd;
            neg = value[VALUE_BITS-1];
            // unsigned negate: the most negative value gives 2^(VALUE_BITS-1)
            mag = neg ? -value : value;
            nd  = 0;
            if (mag == '0) begin
                push_char(CHAR_ZERO, 1'b1);
                return;
            end
            // low digit first; stops at MAX_DIGITS (digit buffer saturation)
            while (mag != '0 && nd < MAX_DIGITS) begin
                digs[nd] = 4'(mag % RADIX);
                mag      = mag / RADIX;
                nd++;
            end
            if (neg)
                push_char(CHAR_MINUS, 1'b0);
            for (int i = nd - 1; i >= 0; i--)
                push_char(CHAR_ZERO + CHAR_BITS'(digs[i]), i == 0);
        endfunction

        function void check_char(logic [CHAR_BITS-1:0] ch, logic last);
            ascii_item_t exp_c;
            if (char_q.size() == 0) begin
                $display("%0t: unexpected character: got char %0d last %0b",
                         $time, ch, last);
                errors++;
                return;
            end
            exp_c = char_q.pop_front();
            if (ch !== exp_c.ch) begin
                $display("%0t: m_ascii_char mismatch: expected %0d, got %0d",
                         $time, exp_c.ch, ch);
                errors++;
            end
            if (last !== exp_c.last) begin
                $display("%0t: m_last mismatch: expected %0b, got %0b",
                         $time, exp_c.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return char_q.size();
        endfunction
    endclass

    // Block ports; every input is known from time zero
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAR_BITS-1:0]  m_ascii_char;
    logic                  m_last;

    // Idling knobs, set per phase by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;
    event long_hold_ev;

    decimal_scoreboard sb;

    signed_decimal_ascii_formatter_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ascii_char(m_ascii_char),
        .m_last      (m_last)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Hard limit; sized for the slowest phases several times over
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: check what was accepted at this edge (values sampled are the
    // pre-edge ones), then pick m_ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_ascii_char, m_last);
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and
    // the block runs into back-pressure on its input.
    always @(long_hold_ev) begin
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Offer one number and wait for it to be taken. Valid is only dropped
    // when an idle gap is actually inserted, so back-to-back items keep
    // s_valid high without a low/high pair in the same step.
    task automatic send_value(logic [VALUE_BITS-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_value(value);
    endtask

    // Random number with a spread of shapes: raw bits, small values, a
    // random digit count, decade boundaries, values near the extremes and raw negatives.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] pow;
        int                    nd;
        pow = 1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: mag = $urandom_range(0, 20);
            2: begin
                nd = $urandom_range(1, 9);
                repeat (nd) pow = pow * RADIX;
                mag = $urandom_range(0, pow - 1);
            end
            3: begin
                nd = $urandom_range(0, 9);
                repeat (nd) pow = pow * RADIX;
                mag = pow + $urandom_range(0, 2) - 1;
            end
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom | 32'h8000_0000;
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Edges of the field, a range of run lengths, zero and the most negative value
    logic [VALUE_BITS-1:0] directed_values [] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
        32'd100, -32'd100, 32'd12345, -32'd54321, 32'd999999999, 32'd1000000000,
        -32'd1000000000, 32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0001,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed numbers, no idling
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // random numbers across the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (PHASE_ITEMS) send_value(random_value());
        end

        // back-pressure: receiver holds off while numbers keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> long_hold_ev;
        repeat (PRESS_ITEMS) send_value(random_value());
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
